FILE: rtl/base64_stream_encoder_unit_macros.svh
// Assertion macros shared by the base64 encoder modules.
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/b64e_pkg.sv
// Package with the shared types, constants and the alphabet lookup of the base64 encoder.
package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [7:0]  PadChar           = 8'h3D;

  // One complete or final group handed from the front to the back.
  typedef struct packed {
    logic [23:0] word;   // three bytes, first byte in the top bits
    logic [1:0]  n_pad;  // number of trailing '=' characters (0..2)
    logic        last;   // group ends the message
  } group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
    logic [7:0] ch;
    if (sextet < 6'd26) begin
      ch = 8'h41 + {2'b00, sextet};
    end else if (sextet < 6'd52) begin
      ch = 8'h61 + {2'b00, sextet - 6'd26};
    end else if (sextet < 6'd62) begin
      ch = 8'h30 + {2'b00, sextet - 6'd52};
    end else if (sextet == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
// Front end: accepts raw bytes, gathers them into groups and issues finished groups.
module b64e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      data_byte_i,
  input  logic            is_final_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            push_o,
  output b64e_pkg::group_t group_o
);
  import b64e_pkg::*;

  logic [1:0]  fill_q, fill_d;
  logic [15:0] pend_q, pend_d;
  logic [1:0]  fill_eff;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_eff   = (fill_q == 2'd3) ? 2'd0 : fill_q;

  always_comb begin
    fill_d        = fill_q;
    pend_d        = pend_q;
    push_o        = 1'b0;
    group_o.word  = {pend_q, data_byte_i};
    group_o.n_pad = 2'd0;
    group_o.last  = is_final_i;
    case (fill_eff)
      2'd0: begin
        group_o.word  = {data_byte_i, 16'h0000};
        group_o.n_pad = 2'd2;
        if (accept) begin
          push_o = is_final_i;
          fill_d = is_final_i ? 2'd0 : 2'd1;
          pend_d = {data_byte_i, 8'h00};
        end
      end
      2'd1: begin
        group_o.word  = {pend_q[15:8], data_byte_i, 8'h00};
        group_o.n_pad = 2'd1;
        if (accept) begin
          push_o = is_final_i;
          fill_d = is_final_i ? 2'd0 : 2'd2;
          pend_d = {pend_q[15:8], data_byte_i};
        end
      end
      default: begin
        if (accept) begin
          push_o = 1'b1;
          fill_d = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

FILE: rtl/b64e_queue.sv
// Short group queue between the front end and the character back end.
`include "base64_stream_encoder_unit_macros.svh"
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64e_pkg::group_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output b64e_pkg::group_t data_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `B64E_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `B64E_ASSERT_IMPLIES(a_no_pop_empty, pop_i, valid_o)
  `B64E_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

FILE: rtl/b64e_back.sv
// Back end: expands one group into four characters and drives the output register.
`include "base64_stream_encoder_unit_macros.svh"
module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  b64e_pkg::group_t q_data_i,
  output logic             pop_o,
  output logic [7:0]       out_char_o,
  output logic             out_last_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);
  import b64e_pkg::*;

  group_t     cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       load, finish;
  logic [5:0] sextet;
  logic [2:0] pad_sum;
  logic       is_pad;
  logic [7:0] char_d;

  assign load   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign finish = load && (idx_q == 2'd3);
  assign pop_o  = q_valid_i && (!cur_valid_q || finish);

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.word[23:18];
      2'd1:    sextet = cur_q.word[17:12];
      2'd2:    sextet = cur_q.word[11:6];
      default: sextet = cur_q.word[5:0];
    endcase
  end

  // A position is a pad once it lies within the last n_pad slots.
  assign pad_sum = {1'b0, idx_q} + {1'b0, cur_q.n_pad};
  assign is_pad  = (pad_sum > 3'd3);
  assign char_d  = is_pad ? PadChar : sextet_char(sextet);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (finish) begin
        cur_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (load) begin
      out_char_q <= char_d;
      out_last_q <= cur_q.last && (idx_q == 2'd3);
    end
  end

  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

  `B64E_ASSERT_IMPLIES(a_idle_idx_zero, !cur_valid_q, idx_q == 2'd0)
  `B64E_ASSERT_NEXT(a_load_fills_out, load, out_valid_q)
  `B64E_ASSERT_NEXT(a_finish_restarts, finish, idx_q == 2'd0)

endmodule

FILE: rtl/base64_stream_encoder_unit.sv
// Top level of the streaming base64 encoder with padded output.
// A group is registered in the queue and in the back end, its characters in the output register.
// Throughput: one character per cycle while a group waits and the receiver is ready.
// Each three-byte group gives four characters, so the output port sets the sustained input rate.
// Reset clears the group fill count, the queue and the output valid; no item is held after reset.
module base64_stream_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);
  import b64e_pkg::*;

  // The front end takes one byte per transfer and keeps up to two bytes
  // pending. A third byte, or any byte marked final, completes a group that
  // is pushed into the queue together with its pad count and last flag.
  group_t front_group;
  group_t queue_group;
  logic   front_push;
  logic   queue_full;
  logic   queue_valid;
  logic   back_pop;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .is_final_i  (is_final_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (queue_full),
    .push_o      (front_push),
    .group_o     (front_group)
  );

  // The queue decouples the two sides, so bytes keep being accepted while the
  // back end is still spelling out an earlier group or is stalled, until the queue is full.
  b64e_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_group),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (back_pop),
    .data_o  (queue_group)
  );

  // The back end walks the four sextets of a group, most significant first,
  // replaces the trailing positions with '=' for a partial final group, and
  // marks the fourth character of a final group as the last one.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_data_i    (queue_group),
    .pop_o       (back_pop),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

FILE: dv/base64_stream_encoder_unit_tb.sv
// Self-checking testbench for the streaming base64 encoder with padded output.
`timescale 1ns / 100ps

module base64_stream_encoder_unit_tb;

  import b64e_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 8;    // extra wait after the last expected character
  localparam int unsigned LongHold    = 300;  // receiver hold-off used to fill the block
  localparam int unsigned PhaseItems  = 45;   // with the directed and hold-off bytes, about 200

  // Standard alphabet indexed by sextet value.
  localparam string B64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic [7:0] data_byte;
  logic       is_final;
  logic       in_valid;
  logic       out_ready;
  logic       in_ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_valid;

  // Encoder state as the testbench sees it: up to two bytes held for the next group.
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  enc_char_t   expected_chars[$];
  enc_char_t   want;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned bytes_sent;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned cycle_count;
  int unsigned fail_count;

  base64_stream_encoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte),
    .is_final_i (is_final),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_char_o (out_char),
    .out_last_o (out_last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready)
  );

  always #2 clk_i = ~clk_i;

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Works out the characters that one accepted byte releases and queues them.
  task automatic predict_encoding(input logic [7:0] b, input logic fin);
    logic [23:0] word;
    int unsigned n_pad;
    enc_char_t   c;
    if (!fin && held_count != 2'd2) begin
      if (held_count == 2'd0) begin
        held_bytes = {b, 8'h00};
      end else begin
        held_bytes[7:0] = b;
      end
      held_count = held_count + 2'd1;
    end else begin
      case (held_count)
        2'd0: begin
          word  = {b, 16'h0000};
          n_pad = 2;
        end
        2'd1: begin
          word  = {held_bytes[15:8], b, 8'h00};
          n_pad = 1;
        end
        default: begin
          word  = {held_bytes, b};
          n_pad = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        if (k < 4 - n_pad) begin
          c.ch = B64Alphabet[(word >> (18 - 6 * k)) & 24'h3F];
        end else begin
          c.ch = PadChar;
        end
        c.last = fin && (k == 3);
        expected_chars = {expected_chars, c};
      end
      held_bytes = '0;
      held_count = '0;
    end
  endtask

  // Offers one byte, idling first at random, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_final  <= fin;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
    predict_encoding(b, fin);
    bytes_sent++;
  endtask

  // Sends one message of the given length with random content.
  task automatic send_message(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Stops offering, waits for every expected character, then lets the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready <= 1'b0;
      end else if (hold_asked != hold_served) begin
        hold_served++;
        out_ready <= 1'b0;
        for (int unsigned n = 0; n < LongHold; n++) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Compares every character transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character transfer: out_char %h out_last %b", out_char, out_last);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %h actual %h", want.ch, out_char);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %b actual %b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Short messages covering every pad case, the alphabet ends and full groups.
  task automatic test_directed();
    send_byte(8'h00, 1'b1);                   // one byte: two characters and two pads
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);                   // two bytes: three characters and one pad
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4D, 1'b0);                   // final byte completes a full group
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFB, 1'b0);                   // inner full group of '+' then one of '/'
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);                   // full group followed by a lone final byte
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h01, 1'b0);                   // full group followed by a final group of two bytes
    send_byte(8'h23, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'h67, 1'b0);
    send_byte(8'h89, 1'b1);
    wait_drained();
  endtask

  // Random messages, mostly short, now and then long.
  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = bytes_sent + PhaseItems;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_message($urandom_range(13, 40));
      end else begin
        send_message($urandom_range(1, 12));
      end
    end
    wait_drained();
  endtask

  // Holds the receiver off while bytes keep coming, so the block fills and stalls its input.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_asked++;
    repeat (4) send_message($urandom_range(5, 10));
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    data_byte     <= 8'h00;
    is_final      <= 1'b0;
    in_valid      <= 1'b0;
    held_bytes     = '0;
    held_count     = '0;
    src_idle_pct   = 22;
    sink_idle_pct  = 65;
    bytes_sent     = 0;
    hold_asked     = 0;
    hold_served    = 0;
    cycle_count    = 0;
    fail_count     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(22, 65);
    test_random(65, 22);
    test_random(0, 0);
    test_backpressure();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_unit.sv
dv/base64_stream_encoder_unit_tb.sv
